[hw/rtl/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// when a holds at an edge, b holds at the same edge
`define ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed: same-cycle implication");

// when a holds at an edge, b holds at the next edge
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed: next-cycle implication");

`endif

[hw/rtl/tdp_pkg.sv]
// shared types and state codes for the trial division primality test
`default_nettype none

package tdp_pkg;

    // control from the sequencer to the serial divider
    typedef struct packed {
        logic start;
    } t_div_ctl;

    // status from the serial divider to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

    // sequencer state encoding
    typedef logic [1:0] t_state;

    localparam t_state ST_IDLE = 2'd0;
    localparam t_state ST_DIV  = 2'd1;
    localparam t_state ST_DONE = 2'd2;

endpackage

`default_nettype wire

[hw/rtl/tdp_div.sv]
// bit-serial restoring divider: one quotient bit per cycle
`default_nettype none

module tdp_div #(
    parameter int NUM_WIDTH = 32
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  tdp_pkg::t_div_ctl       i_ctl,
    input  wire [NUM_WIDTH-1:0]     i_dividend,
    input  wire [NUM_WIDTH-1:0]     i_divisor,
    output tdp_pkg::t_div_sts       o_sts,
    output logic [NUM_WIDTH-1:0]    o_quotient,
    output logic [NUM_WIDTH-1:0]    o_remainder
);
    import tdp_pkg::*;

    localparam int CNT_W = (NUM_WIDTH > 1) ? $clog2(NUM_WIDTH) : 1;

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [NUM_WIDTH-1:0] r_dvd, n_dvd;
    logic [NUM_WIDTH-1:0] r_dsr, n_dsr;
    logic [NUM_WIDTH-1:0] r_quo, n_quo;
    logic [NUM_WIDTH-1:0] r_rem, n_rem;

    logic [NUM_WIDTH:0]   trial;
    logic [NUM_WIDTH:0]   diff;
    logic                 fits;

    // one restoring step: bring down the next dividend bit and try the subtract
    always_comb begin
        trial = {r_rem, r_dvd[NUM_WIDTH-1]};
        diff  = trial - {1'b0, r_dsr};
        fits  = (trial >= {1'b0, r_dsr});
    end

    // step sequencing
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_dsr  = r_dsr;
        n_quo  = r_quo;
        n_rem  = r_rem;
        if (i_ctl.start && !r_busy) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_dvd  = i_dividend;
            n_dsr  = i_divisor;
            n_quo  = '0;
            n_rem  = '0;
        end else if (r_busy) begin
            n_dvd = {r_dvd[NUM_WIDTH-2:0], 1'b0};
            n_quo = {r_quo[NUM_WIDTH-2:0], fits};
            n_rem = fits ? diff[NUM_WIDTH-1:0] : trial[NUM_WIDTH-1:0];
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(NUM_WIDTH - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // datapath shift registers
    always_ff @(posedge i_clk) begin
        r_dvd <= n_dvd;
        r_dsr <= n_dsr;
        r_quo <= n_quo;
        r_rem <= n_rem;
    end

    assign o_sts.busy  = r_busy;
    assign o_sts.done  = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

[hw/rtl/trial_division_primality_test.sv]
// Trial division primality test. Each transaction on the input channel carries one
// unsigned candidate and produces exactly one is_prime result. Zero, one, two and even
// numbers above two are decided without the divider. An odd candidate of three or more is
// divided by 3, 5, 7, ... until a divisor leaves no remainder or the divisor exceeds
// the quotient; each trial divisor runs through the bit-serial divider, which produces
// one quotient bit per cycle. One candidate is worked on at a time; a finished result
// waits in the output register while the next candidate is accepted.
`default_nettype none

module trial_division_primality_test #(
    parameter int NUM_WIDTH = 32
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  wire [NUM_WIDTH-1:0]  i_candidate,
    output logic                 o_valid,
    input  wire                  i_ready,
    output logic                 o_is_prime
);
    import tdp_pkg::*;

    t_state               r_state, n_state;
    logic                 r_start, n_start;
    logic                 r_out_valid, n_out_valid;
    logic [NUM_WIDTH-1:0] r_num, n_num;
    logic [NUM_WIDTH-1:0] r_x, n_x;
    logic                 r_res, n_res;
    logic                 r_is_prime, n_is_prime;

    t_div_ctl             div_ctl;
    t_div_sts             div_sts;
    logic [NUM_WIDTH-1:0] div_quo;
    logic [NUM_WIDTH-1:0] div_rem;

    // serial divider computes candidate / x and candidate % x
    assign div_ctl.start = r_start;

    tdp_div #(
        .NUM_WIDTH (NUM_WIDTH)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (div_ctl),
        .i_dividend  (r_num),
        .i_divisor   (r_x),
        .o_sts       (div_sts),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_start     = 1'b0;
        n_out_valid = r_out_valid;
        n_num       = r_num;
        n_x         = r_x;
        n_res       = r_res;
        n_is_prime  = r_is_prime;

        // output transaction frees the result register
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_num = i_candidate;
                    if (i_candidate[NUM_WIDTH-1:1] == '0) begin
                        // zero and one
                        n_res   = 1'b0;
                        n_state = ST_DONE;
                    end else if (i_candidate == NUM_WIDTH'(2)) begin
                        n_res   = 1'b1;
                        n_state = ST_DONE;
                    end else if (!i_candidate[0]) begin
                        n_res   = 1'b0;
                        n_state = ST_DONE;
                    end else begin
                        n_x     = NUM_WIDTH'(3);
                        n_start = 1'b1;
                        n_state = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (div_sts.done) begin
                    if (r_x > div_quo) begin
                        // divisor passed the square root
                        n_res   = 1'b1;
                        n_state = ST_DONE;
                    end else if (div_rem == '0) begin
                        n_res   = 1'b0;
                        n_state = ST_DONE;
                    end else begin
                        n_x     = r_x + NUM_WIDTH'(2);
                        n_start = 1'b1;
                    end
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_is_prime  = r_res;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_start     <= n_start;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_num      <= n_num;
        r_x        <= n_x;
        r_res      <= n_res;
        r_is_prime <= n_is_prime;
    end

    assign o_ready    = (r_state == ST_IDLE);
    assign o_valid    = r_out_valid;
    assign o_is_prime = r_is_prime;

endmodule

`default_nettype wire

[hw/rtl/tdp_chk.sv]
// port-level checker for the primality test, bound to the top level
`default_nettype none

`include "assert_macros.svh"

module tdp_chk (
    input wire i_clk,
    input wire i_rst_n,
    input wire i_valid,
    input wire o_ready,
    input wire o_valid,
    input wire i_ready,
    input wire o_is_prime
);

    // a stalled result stays offered
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)

    // a stalled result keeps its value
    `ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_valid && !i_ready, $stable(o_is_prime))

    // after taking a candidate the block is busy in the following cycle
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && o_ready, !o_ready)

    // a new result only appears when the block was busy in the previous cycle
    `ASSERT_SAME(a_result_after_work, i_clk, i_rst_n, $rose(o_valid), !$past(o_ready))

endmodule

bind trial_division_primality_test tdp_chk u_tdp_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_ready    (o_ready),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_is_prime (o_is_prime)
);

`default_nettype wire
